>>> design/led_effect_pattern_generator_assert.svh
// Assertion macros for the LED effect pattern generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LED_EFFECT_PATTERN_GENERATOR_ASSERT_SVH
`define LED_EFFECT_PATTERN_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check on every rising edge outside reset.
`define LEPG_ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lepg: assertion failed");
// Check on every rising edge, reset included.
`define LEPG_ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lepg: assertion failed");
`else
`define LEPG_ASSERT_RST(lbl, clk, rst_n, prop)
`define LEPG_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

>>> design/lepg_pkg.sv
// Shared types and constants for the LED effect pattern generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package lepg_pkg;

	typedef enum logic [3:0] {
		EFF_OFF     = 4'd0,
		EFF_ON      = 4'd1,
		EFF_SLOW    = 4'd2,
		EFF_FAST    = 4'd3,
		EFF_BREATHE = 4'd4,
		EFF_PULSE   = 4'd5,
		EFF_STROBE  = 4'd6,
		EFF_CANDLE  = 4'd7,
		EFF_MORSE   = 4'd8
	} effect_t;

	typedef enum logic [1:0] {
		REG_PWM_PERIOD  = 2'd0,
		REG_DASH_MASK   = 2'd1,
		REG_MORSE_LEN   = 2'd2,
		REG_CANDLE_SEED = 2'd3
	} reg_index_t;

	localparam logic [7:0]  PWM_PERIOD_RST  = 8'd20;
	localparam logic [15:0] DASH_MASK_RST   = 16'd56;
	localparam logic [4:0]  MORSE_LEN_RST   = 5'd9;
	localparam logic [15:0] CANDLE_SEED_RST = 16'd44257;

	// Live configuration seen by the effect logic.
	typedef struct packed {
		logic [7:0]  pwm_period;
		logic [15:0] dash_mask;
		logic [4:0]  morse_length;
	} cfg_t;

	// Pre-reduced random draws for the next candle update.
	typedef struct packed {
		logic       ok;
		logic [3:0] step_mod17;
		logic [6:0] wait_mod90;
	} rnd_t;

endpackage

`default_nettype wire

>>> design/lepg_rand.sv
// Candle random source: 16-bit Galois LFSR with two draws reduced ahead of use.
// Depends on lepg_pkg.
`default_nettype none

module lepg_rand (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          seed_load,
	input  wire logic [15:0]   seed,
	input  wire logic          draw,
	output lepg_pkg::rnd_t     rnd
);
	import lepg_pkg::*;

	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam logic [15:0] RECIP_90  = 16'd46604;	// ceil(2^22 / 90)

	logic [15:0] lfsr_q;
	logic [15:0] next_q;
	logic [3:0]  m17_q;
	logic [6:0]  m90_q;
	logic        ok_q;

	logic [15:0] r1;
	logic [15:0] r2;
	logic [6:0]  fold;
	logic [3:0]  m17;
	logic [31:0] prod90;
	logic [9:0]  quot90;
	logic [16:0] rem90;
	logic [6:0]  m90;
	logic [15:0] seed_val;

	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
	endfunction

	always_comb begin
		r1 = lfsr_step(lfsr_q);
		r2 = lfsr_step(r1);

		// 16 = -1 mod 17: alternate nibble sum, offset by 34 to stay positive
		fold = 7'd34 + {3'b000, r1[3:0]} + {3'b000, r1[11:8]}
			- {3'b000, r1[7:4]} - {3'b000, r1[15:12]};
		if (fold >= 7'd51) begin
			m17 = 4'(fold - 7'd51);
		end else if (fold >= 7'd34) begin
			m17 = 4'(fold - 7'd34);
		end else if (fold >= 7'd17) begin
			m17 = 4'(fold - 7'd17);
		end else begin
			m17 = fold[3:0];
		end

		// reciprocal quotient, then remainder with one correction step
		prod90 = {16'd0, r2} * {16'd0, RECIP_90};
		quot90 = prod90[31:22];
		rem90  = {1'b0, r2} - (({7'd0, quot90} << 6) + ({7'd0, quot90} << 4)
			+ ({7'd0, quot90} << 3) + ({7'd0, quot90} << 1));
		if (rem90 >= 17'd90) begin
			m90 = 7'(rem90 - 17'd90);
		end else begin
			m90 = rem90[6:0];
		end

		seed_val = (seed == 16'd0) ? 16'd1 : seed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= CANDLE_SEED_RST;
			ok_q   <= 1'b0;
		end else begin
			if (seed_load) begin
				lfsr_q <= seed_val;
			end else if (draw) begin
				lfsr_q <= next_q;
			end
			ok_q <= !(seed_load || draw);
		end
	end

	always_ff @(posedge clk) begin
		next_q <= r2;
		m17_q  <= m17;
		m90_q  <= m90;
	end

	assign rnd = '{ok: ok_q, step_mod17: m17_q, wait_mod90: m90_q};

endmodule

`default_nettype wire

>>> design/lepg_core.sv
// Effect state and per-tick level logic for the LED effect pattern generator.
// Depends on lepg_pkg and led_effect_pattern_generator_assert.svh.
`default_nettype none
`include "led_effect_pattern_generator_assert.svh"

module lepg_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          upd,
	input  wire logic          press,
	input  lepg_pkg::cfg_t     cfg,
	input  lepg_pkg::rnd_t     rnd,
	output logic               need_draw,
	output logic               lit,
	output lepg_pkg::effect_t  effect
);
	import lepg_pkg::*;

	effect_t     effect_q;
	logic [7:0]  pwm_phase_q;
	logic [7:0]  br_tens_q;
	logic [3:0]  br_ones_q;
	logic [9:0]  hb_phase_q;
	logic [5:0]  st_phase_q;
	logic [9:0]  blink_el_q;
	logic        blink_lvl_q;
	logic [6:0]  candle_lvl_q;
	logic [6:0]  candle_wait_q;
	logic [3:0]  morse_pos_q;
	logic        morse_lit_q;
	logic [9:0]  morse_rem_q;

	effect_t     eff_sel;
	logic [7:0]  period_eff;
	logic [4:0]  len_eff;
	logic [7:0]  br_tens;
	logic [3:0]  br_ones;
	logic [9:0]  hb_phase;
	logic [5:0]  st_phase;
	logic [9:0]  blink_el;
	logic        blink_lvl;
	logic [9:0]  blink_limit;
	logic [7:0]  cand_sum;
	logic [6:0]  candle_lvl_n;
	logic [6:0]  wait_cur;
	logic [7:0]  br_fall;
	logic [6:0]  br_duty;
	logic [6:0]  duty;
	logic [14:0] pwm_prod;
	logic [8:0]  phase_inc;
	logic [15:0] pwm_thr;
	logic        pwm_on;
	logic [3:0]  morse_pos;
	logic        morse_lit;
	logic [9:0]  morse_rem;

	always_comb begin
		eff_sel = effect_q;
		if (press) begin
			eff_sel = (effect_q == EFF_MORSE) ? EFF_OFF : effect_t'(effect_q + 4'd1);
		end

		period_eff = (cfg.pwm_period == 8'd0) ? 8'd1 : cfg.pwm_period;
		if (cfg.morse_length == 5'd0) begin
			len_eff = 5'd1;
		end else if (cfg.morse_length > 5'd16) begin
			len_eff = 5'd16;
		end else begin
			len_eff = cfg.morse_length;
		end

		// restart timers on a press
		br_tens   = press ? 8'd0 : br_tens_q;
		br_ones   = press ? 4'd0 : br_ones_q;
		hb_phase  = press ? 10'd0 : hb_phase_q;
		st_phase  = press ? 6'd0 : st_phase_q;
		blink_el  = press ? 10'd0 : blink_el_q;
		morse_pos = press ? 4'd0 : morse_pos_q;
		morse_lit = press ? 1'b0 : morse_lit_q;
		morse_rem = press ? 10'd0 : morse_rem_q;
		blink_lvl = blink_lvl_q;

		// candle
		need_draw = (eff_sel == EFF_CANDLE) && (candle_wait_q == 7'd0);
		cand_sum  = {1'b0, candle_lvl_q} + {4'd0, rnd.step_mod17};
		if (!need_draw) begin
			candle_lvl_n = candle_lvl_q;
		end else if (cand_sum < 8'd48) begin
			candle_lvl_n = 7'd40;
		end else if (cand_sum > 8'd103) begin
			candle_lvl_n = 7'd95;
		end else begin
			candle_lvl_n = 7'(cand_sum - 8'd8);
		end
		wait_cur = need_draw ? (7'd30 + rnd.wait_mod90) : candle_wait_q;

		// breathe duty from tens and units of the phase
		br_fall = (br_ones == 4'd0) ? (8'd200 - br_tens) : (8'd199 - br_tens);
		br_duty = (br_tens < 8'd100) ? br_tens[6:0] : br_fall[6:0];

		// phase < floor(P * duty / 100)  <=>  100 * (phase + 1) <= P * duty
		duty      = (eff_sel == EFF_CANDLE) ? candle_lvl_n : br_duty;
		pwm_prod  = {7'd0, period_eff} * {8'd0, duty};
		phase_inc = {1'b0, pwm_phase_q} + 9'd1;
		pwm_thr   = ({7'd0, phase_inc} << 6) + ({7'd0, phase_inc} << 5)
			+ ({7'd0, phase_inc} << 2);
		pwm_on    = pwm_thr <= {1'b0, pwm_prod};

		// blink
		blink_limit = (eff_sel == EFF_SLOW) ? 10'd500 : 10'd100;
		if ((eff_sel == EFF_SLOW || eff_sel == EFF_FAST) && blink_el >= blink_limit) begin
			blink_el  = 10'd0;
			blink_lvl = !blink_lvl_q;
		end

		// morse sequencer
		if (eff_sel == EFF_MORSE && morse_rem == 10'd0) begin
			if (!morse_lit) begin
				if ({1'b0, morse_pos} >= len_eff) begin
					morse_pos = 4'd0;
					morse_rem = 10'd200;
				end else begin
					morse_rem = cfg.dash_mask[morse_pos] ? 10'd600 : 10'd200;
				end
				morse_lit = 1'b1;
			end else begin
				morse_lit = 1'b0;
				if ({1'b0, morse_pos} + 5'd1 >= len_eff) begin
					morse_pos = 4'd0;
					morse_rem = 10'd400;
				end else begin
					morse_pos = morse_pos + 4'd1;
					morse_rem = 10'd200;
				end
			end
		end

		case (eff_sel) inside
			EFF_ON:               lit = 1'b1;
			EFF_SLOW, EFF_FAST:   lit = blink_lvl;
			EFF_BREATHE, EFF_CANDLE: lit = pwm_on;
			EFF_PULSE:            lit = (hb_phase < 10'd70)
				|| (hb_phase >= 10'd150 && hb_phase < 10'd220);
			EFF_STROBE:           lit = st_phase < 6'd10;
			EFF_MORSE:            lit = morse_lit;
			default:              lit = 1'b0;
		endcase

		effect = eff_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_q      <= EFF_BREATHE;
			pwm_phase_q   <= 8'd0;
			br_tens_q     <= 8'd0;
			br_ones_q     <= 4'd0;
			hb_phase_q    <= 10'd0;
			st_phase_q    <= 6'd0;
			blink_el_q    <= 10'd0;
			blink_lvl_q   <= 1'b0;
			candle_lvl_q  <= 7'd40;
			candle_wait_q <= 7'd0;
			morse_pos_q   <= 4'd0;
			morse_lit_q   <= 1'b0;
			morse_rem_q   <= 10'd0;
		end else if (upd) begin
			effect_q    <= eff_sel;
			pwm_phase_q <= (phase_inc >= {1'b0, period_eff}) ? 8'd0 : phase_inc[7:0];
			if (br_ones == 4'd9) begin
				br_ones_q <= 4'd0;
				br_tens_q <= (br_tens == 8'd199) ? 8'd0 : br_tens + 8'd1;
			end else begin
				br_ones_q <= br_ones + 4'd1;
				br_tens_q <= br_tens;
			end
			hb_phase_q    <= (hb_phase == 10'd819) ? 10'd0 : hb_phase + 10'd1;
			st_phase_q    <= (st_phase == 6'd49) ? 6'd0 : st_phase + 6'd1;
			blink_el_q    <= (blink_el == 10'd1023) ? blink_el : blink_el + 10'd1;
			blink_lvl_q   <= blink_lvl;
			candle_lvl_q  <= candle_lvl_n;
			candle_wait_q <= (wait_cur == 7'd0) ? 7'd0 : wait_cur - 7'd1;
			morse_pos_q   <= morse_pos;
			morse_lit_q   <= morse_lit;
			morse_rem_q   <= (morse_rem == 10'd0) ? 10'd0 : morse_rem - 10'd1;
		end
	end

	`LEPG_ASSERT_RST(a_candle_level_range, clk, arst_n, candle_lvl_q >= 7'd40 && candle_lvl_q <= 7'd95)
	`LEPG_ASSERT_RST(a_candle_wait_bound, clk, arst_n, candle_wait_q <= 7'd118)
	`LEPG_ASSERT_RST(a_draw_reloads_wait, clk, arst_n, upd && need_draw |=> candle_wait_q >= 7'd29)
	`LEPG_ASSERT_RST(a_press_wraps, clk, arst_n, upd && press && effect_q == EFF_MORSE |=> effect_q == EFF_OFF)

endmodule

`default_nettype wire

>>> design/led_effect_pattern_generator.sv
// Top level of the LED effect pattern generator: ports, configuration registers,
// input and result registers. Depends on lepg_pkg, lepg_rand and lepg_core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   cfg     | in        | cfg_write          | cfg_index, cfg_wdata
//   in      | in        | in_valid, in_stall | button_press (one tick)
//   out     | out       | out_valid,out_stall| led_lit, effect_now
//
// One tick per clock: a transfer on in is registered, evaluated from the
// input register and lands in the result register when it advances, and the
// result is offered from there until it moves on; a new tick may follow on
// every edge unless out_stall or a draw that is not ready holds it back.
// The LFSR draws are reduced ahead of use; after a candle seed write a tick
// that needs a draw waits in the input register until they are ready again.
// Reset restores the register defaults, breathe as the active effect and the
// seed loaded into the LFSR. A stalled result holds; in_stall rises only when
// the input register is full and cannot move on.
`default_nettype none

module led_effect_pattern_generator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_write,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         button_press,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              led_lit,
	output logic [3:0]        effect_now
);
	import lepg_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic        press_s1;
	logic        valid_s2;
	logic        led_lit_s2;
	effect_t     effect_s2;

	rnd_t        rnd;
	logic        need_draw;
	logic        core_lit;
	effect_t     core_effect;
	logic        adv;
	logic        seed_load;

	// Advance the input register when the result register is free and any
	// random draw it needs is ready.
	assign adv       = valid_s1 && (!valid_s2 || !out_stall) && (rnd.ok || !need_draw);
	assign in_stall  = valid_s1 && !adv;
	assign seed_load = cfg_write && (reg_index_t'(cfg_index) == REG_CANDLE_SEED);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period   <= PWM_PERIOD_RST;
			cfg_q.dash_mask    <= DASH_MASK_RST;
			cfg_q.morse_length <= MORSE_LEN_RST;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_PWM_PERIOD: cfg_q.pwm_period   <= cfg_wdata[7:0];
				REG_DASH_MASK:  cfg_q.dash_mask    <= cfg_wdata;
				REG_MORSE_LEN:  cfg_q.morse_length <= cfg_wdata[4:0];
				REG_CANDLE_SEED: begin
					// seed goes straight into the LFSR
				end
				default: begin
				end
			endcase
		end
	end

	// Input and result valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || adv) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload: capture on an input transfer, hold the result until it moves on.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			press_s1 <= button_press;
		end
		if (adv) begin
			led_lit_s2 <= core_lit;
			effect_s2  <= core_effect;
		end
	end

	lepg_rand u_rand (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (seed_load),
		.seed      (cfg_wdata),
		.draw      (adv && need_draw),
		.rnd       (rnd)
	);

	lepg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv),
		.press     (press_s1),
		.cfg       (cfg_q),
		.rnd       (rnd),
		.need_draw (need_draw),
		.lit       (core_lit),
		.effect    (core_effect)
	);

	assign out_valid  = valid_s2;
	assign led_lit    = led_lit_s2;
	assign effect_now = effect_s2;

endmodule

`default_nettype wire
